>>> rtl/rsrd_pkg.sv
// ----------------------------------------------------------------------------
// rsrd_pkg
// Shared types, constants and the RGBE-to-binary16 conversion function for the
// RGBE scanline run-length decoder.
// ----------------------------------------------------------------------------
package rsrd_pkg;

  localparam int MAX_ROW_PIXELS = 4096;
  localparam int COL_W          = $clog2(MAX_ROW_PIXELS);

  localparam logic [7:0]  HDR_TAG      = 8'd2;
  localparam logic [7:0]  RUN_BASE     = 8'h80;
  localparam logic [14:0] FLAT_MIN_W   = 15'd8;
  localparam logic [14:0] ROW_MAX_W    = 15'(MAX_ROW_PIXELS);
  localparam logic [1:0]  HDR_LAST_IDX = 2'd3;

  // configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_HEADER  = 2'd1,
    ERR_OVERRUN = 2'd2,
    ERR_WIDTH   = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_COUNT   = 2'd1,
    PH_RUNVAL  = 2'd2,
    PH_LITERAL = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RUN,
    S_CONV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_start;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  pixel_count;
    logic [15:0] red_first;
    logic [15:0] green_first;
    logic [15:0] blue_first;
    logic [15:0] red_second;
    logic [15:0] green_second;
    logic [15:0] blue_second;
    logic        row_end;
    logic        image_end;
    logic        last_of_run;
    logic [1:0]  error_code;
  } out_word_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } pix_t;

  // mantissa * 2^(e-136) as binary16, round to nearest even
  function automatic logic [15:0] to_half(input logic [7:0] m, input logic [7:0] e);
    logic signed [9:0] k;
    logic signed [9:0] ex;
    logic signed [9:0] eb;
    logic signed [9:0] sh;
    logic signed [9:0] s;
    logic [2:0]        t;
    logic [17:0]       ms;
    logic [15:0]       res;
    logic [7:0]        q;
    logic [8:0]        rem;
    logic [8:0]        half;
    logic [8:0]        mask;
    k    = $signed({2'b00, e}) - 10'sd136;
    t    = 3'd0;
    ms   = '0;
    res  = '0;
    q    = '0;
    rem  = '0;
    half = '0;
    mask = '0;
    for (int i = 1; i < 8; i++) begin
      if (m[i]) begin
        t = 3'(i);
      end
    end
    ex = k + $signed({7'b0, t});
    eb = ex + 10'sd15;
    sh = k + 10'sd24;
    s  = -sh;
    if (e == 8'd0 || m == 8'd0) begin
      res = 16'h0000;
    end else if (ex > 10'sd15) begin
      res = 16'h7C00;
    end else if (ex >= -10'sd14) begin
      ms  = {10'b0, m} << (4'd10 - {1'b0, t});
      res = {1'b0, eb[4:0], ms[9:0]};
    end else if (sh >= 10'sd0) begin
      res = {8'b0, m} << sh[3:0];
    end else if (s >= 10'sd9) begin
      res = 16'h0000;
    end else begin
      q    = m >> s[3:0];
      mask = (9'd1 << s[3:0]) - 9'd1;
      rem  = {1'b0, m} & mask;
      half = 9'd1 << (s[3:0] - 4'd1);
      if (rem > half || (rem == half && q[0])) begin
        q = q + 8'd1;
      end
      res = {8'b0, q};
    end
    return res;
  endfunction

endpackage

>>> rtl/rsrd_plane_ram.sv
// ----------------------------------------------------------------------------
// rsrd_plane_ram
// Row buffer for the red, green and blue planes: one entry per column, one
// byte lane per plane, byte-lane write enables and a registered read port.
// ----------------------------------------------------------------------------
module rsrd_plane_ram (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [2:0]                wr_be,
  input  logic [rsrd_pkg::COL_W-1:0] wr_addr,
  input  logic [7:0]                wr_data,
  input  logic                      rd_en,
  input  logic [rsrd_pkg::COL_W-1:0] rd_addr,
  output logic [23:0]               rd_data
);
  import rsrd_pkg::*;

  logic [23:0] mem [MAX_ROW_PIXELS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int j = 0; j < 3; j++) begin
        if (wr_be[j]) begin
          mem[wr_addr][8*j +: 8] <= wr_data;
        end
      end
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/rsrd_pixel_conv.sv
// ----------------------------------------------------------------------------
// rsrd_pixel_conv
// Converts one RGBE pixel to three binary16 channel values.
// ----------------------------------------------------------------------------
module rsrd_pixel_conv (
  input  logic [7:0]     red_m,
  input  logic [7:0]     green_m,
  input  logic [7:0]     blue_m,
  input  logic [7:0]     expo,
  output rsrd_pkg::pix_t px
);
  import rsrd_pkg::*;

  assign px.red   = to_half(red_m, expo);
  assign px.green = to_half(green_m, expo);
  assign px.blue  = to_half(blue_m, expo);

endmodule

>>> rtl/rgbe_scanline_rle_decoder_unit.sv
// ----------------------------------------------------------------------------
// rgbe_scanline_rle_decoder_unit
// Decodes the pixel bytes of an RGBE image (flat or run-length rows) into
// binary16 red, green and blue, up to two pixels per output word.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one data byte per word; frame_start marks the first byte of an
//           image and clears all row state before that byte is decoded.
//   out_* : decoded pixels, row/image end flags, last_of_run on the final
//           word of each input byte and the error code on that word.
//   cfg_* : image width (index 0) and height (index 1); write while idle.
// Timing: the block works on one byte at a time. Each byte is accepted
//   (S_IDLE), decoded (S_DECODE) and finished (S_FIN). A byte that fills
//   plane positions passes through S_RUN for each position and once more
//   at the end; each exponent position also passes through S_CONV for the
//   row buffer read (one read port, registered data) and conversion.
// Reset: width 8, height 1, row state cleared, no error latched. The row
//   buffer is not cleared; every entry is written before it is read.
// Stall: one output register holds a finished word; while it is stalled the
//   decoder waits at its next word and in_stall stays high.
// ----------------------------------------------------------------------------
module rgbe_scanline_rle_decoder_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rsrd_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rsrd_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [15:0]         cfg_wdata
);
  import rsrd_pkg::*;

  state_t      state_r, state_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        fs_r, fs_nxt;
  logic [14:0] width_r;
  logic [15:0] height_r;
  logic [16:0] w3_r;
  logic [14:0] pos_r, pos_nxt;
  phase_t      phase_r, phase_nxt;
  logic [1:0]  hidx_r, hidx_nxt;
  logic [7:0]  lit_r, lit_nxt;
  logic [15:0] row_r, row_nxt;
  logic [23:0] fpb_r, fpb_nxt;
  logic [1:0]  sticky_r, sticky_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [1:0]  err_r, err_nxt;
  logic [1:0]  pend_cnt_r, pend_cnt_nxt;
  pix_t        px0_r, px0_nxt, px1_r, px1_nxt;
  logic        pend_re_r, pend_re_nxt, pend_ie_r, pend_ie_nxt;
  logic        cur_re_r, cur_re_nxt, cur_ie_r, cur_ie_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_data_r, out_data_nxt;

  // effective state after an optional frame restart
  logic [14:0] e_pos;
  phase_t      e_phase;
  logic [1:0]  e_hidx;
  logic [7:0]  e_lit;
  logic [15:0] e_row;
  logic [23:0] e_fpb;
  logic [1:0]  e_sticky;

  logic [16:0] w17, w2, w4, pos17, e_pos17, space;
  logic        flat, w_big, img_done, hdr_bad, out_free;
  logic        flat_rend, flat_iend;
  logic [15:0] flat_pinc;
  logic [7:0]  cnt_n;
  logic [16:0] col17;
  logic [2:0]  plane_be;

  logic        ram_we, ram_re;
  logic [23:0] ram_rdata;
  logic [7:0]  cv_r, cv_g, cv_b;
  pix_t        cv_px;

  assign w17   = {2'b00, width_r};
  assign w2    = {1'b0, width_r, 1'b0};
  assign w4    = {width_r, 2'b00};
  assign pos17 = {2'b00, pos_r};

  assign e_pos    = fs_r ? '0 : pos_r;
  assign e_phase  = fs_r ? PH_HEADER : phase_r;
  assign e_hidx   = fs_r ? '0 : hidx_r;
  assign e_lit    = fs_r ? '0 : lit_r;
  assign e_row    = fs_r ? '0 : row_r;
  assign e_fpb    = fs_r ? '0 : fpb_r;
  assign e_sticky = fs_r ? '0 : sticky_r;
  assign e_pos17  = {2'b00, e_pos};

  assign flat     = (width_r < FLAT_MIN_W) || height_r[15];
  assign w_big    = width_r > ROW_MAX_W;
  assign img_done = (e_row >= height_r) || (flat && width_r == '0);
  assign hdr_bad  = (e_fpb[7:0] != HDR_TAG) || (e_fpb[15:8] != HDR_TAG) || e_fpb[23] ||
                    ({e_fpb[22:16], byte_r} != width_r);
  assign cnt_n    = (byte_r > RUN_BASE) ? (byte_r - RUN_BASE) : byte_r;
  assign space    = (e_pos17 < w4) ? (w4 - e_pos17) : '0;
  assign out_free = !out_valid_r || !out_stall;

  assign flat_pinc = {1'b0, e_pos} + 16'd1;
  assign flat_rend = flat_pinc >= {1'b0, width_r};
  assign flat_iend = flat_rend && (({1'b0, e_row} + 17'd1) >= {1'b0, height_r});

  // plane and column of the current write position
  always_comb begin
    if (pos17 < w17) begin
      col17    = pos17;
      plane_be = 3'b001;
    end else if (pos17 < w2) begin
      col17    = pos17 - w17;
      plane_be = 3'b010;
    end else if (pos17 < w3_r) begin
      col17    = pos17 - w2;
      plane_be = 3'b100;
    end else begin
      col17    = pos17 - w3_r;
      plane_be = 3'b000;
    end
  end

  assign cv_r = (state_r == S_DECODE) ? e_fpb[7:0]   : ram_rdata[7:0];
  assign cv_g = (state_r == S_DECODE) ? e_fpb[15:8]  : ram_rdata[15:8];
  assign cv_b = (state_r == S_DECODE) ? e_fpb[23:16] : ram_rdata[23:16];

  rsrd_pixel_conv u_conv (
    .red_m   (cv_r),
    .green_m (cv_g),
    .blue_m  (cv_b),
    .expo    (byte_r),
    .px      (cv_px)
  );

  rsrd_plane_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_be   (plane_be),
    .wr_addr (col17[COL_W-1:0]),
    .wr_data (byte_r),
    .rd_en   (ram_re),
    .rd_addr (col17[COL_W-1:0]),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    byte_nxt      = byte_r;
    fs_nxt        = fs_r;
    pos_nxt       = pos_r;
    phase_nxt     = phase_r;
    hidx_nxt      = hidx_r;
    lit_nxt       = lit_r;
    row_nxt       = row_r;
    fpb_nxt       = fpb_r;
    sticky_nxt    = sticky_r;
    rem_nxt       = rem_r;
    err_nxt       = err_r;
    pend_cnt_nxt  = pend_cnt_r;
    px0_nxt       = px0_r;
    px1_nxt       = px1_r;
    pend_re_nxt   = pend_re_r;
    pend_ie_nxt   = pend_ie_r;
    cur_re_nxt    = cur_re_r;
    cur_ie_nxt    = cur_ie_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          byte_nxt  = in_data.in_byte;
          fs_nxt    = in_data.frame_start;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        pos_nxt      = e_pos;
        phase_nxt    = e_phase;
        hidx_nxt     = e_hidx;
        lit_nxt      = e_lit;
        row_nxt      = e_row;
        fpb_nxt      = e_fpb;
        sticky_nxt   = e_sticky;
        err_nxt      = ERR_NONE;
        pend_cnt_nxt = '0;
        pend_re_nxt  = 1'b0;
        pend_ie_nxt  = 1'b0;
        state_nxt    = S_FIN;
        if (e_sticky != ERR_NONE) begin
          err_nxt = e_sticky;
        end else if (img_done) begin
          state_nxt = S_IDLE;
        end else if (flat) begin
          if (e_hidx != HDR_LAST_IDX) begin
            fpb_nxt[8*e_hidx +: 8] = byte_r;
            hidx_nxt = e_hidx + 2'd1;
          end else begin
            px0_nxt      = cv_px;
            pend_cnt_nxt = 2'd1;
            pend_re_nxt  = flat_rend;
            pend_ie_nxt  = flat_iend;
            hidx_nxt     = '0;
            fpb_nxt      = '0;
            if (flat_rend) begin
              pos_nxt = '0;
              row_nxt = e_row + 16'd1;
            end else begin
              pos_nxt = flat_pinc[14:0];
            end
          end
        end else if (w_big) begin
          sticky_nxt = ERR_WIDTH;
          err_nxt    = ERR_WIDTH;
        end else begin
          unique case (e_phase)
            PH_HEADER: begin
              if (e_hidx != HDR_LAST_IDX) begin
                fpb_nxt[8*e_hidx +: 8] = byte_r;
                hidx_nxt = e_hidx + 2'd1;
              end else if (hdr_bad) begin
                sticky_nxt = ERR_HEADER;
                err_nxt    = ERR_HEADER;
              end else begin
                phase_nxt = PH_COUNT;
                hidx_nxt  = '0;
                fpb_nxt   = '0;
                pos_nxt   = '0;
              end
            end
            PH_COUNT: begin
              if ({9'b0, cnt_n} > space) begin
                err_nxt = ERR_OVERRUN;
              end
              if (cnt_n != '0) begin
                lit_nxt   = cnt_n;
                phase_nxt = (byte_r > RUN_BASE) ? PH_RUNVAL : PH_LITERAL;
              end else if (e_pos17 >= w4) begin
                // row already full: close it
                pos_nxt   = '0;
                row_nxt   = e_row + 16'd1;
                phase_nxt = PH_HEADER;
                hidx_nxt  = '0;
                fpb_nxt   = '0;
              end
            end
            PH_RUNVAL: begin
              rem_nxt   = e_lit;
              lit_nxt   = '0;
              phase_nxt = PH_COUNT;
              state_nxt = S_RUN;
            end
            PH_LITERAL: begin
              rem_nxt   = 8'd1;
              lit_nxt   = (e_lit != '0) ? e_lit - 8'd1 : '0;
              phase_nxt = (e_lit <= 8'd1) ? PH_COUNT : PH_LITERAL;
              state_nxt = S_RUN;
            end
          endcase
        end
      end

      S_RUN: begin
        if (rem_r == '0 || pos17 >= w4) begin
          rem_nxt   = '0;
          state_nxt = S_FIN;
          if (phase_r == PH_COUNT && pos17 >= w4) begin
            pos_nxt   = '0;
            row_nxt   = row_r + 16'd1;
            phase_nxt = PH_HEADER;
            hidx_nxt  = '0;
            fpb_nxt   = '0;
          end
        end else begin
          pos_nxt = pos_r + 15'd1;
          rem_nxt = rem_r - 8'd1;
          if (pos17 < w3_r) begin
            ram_we = 1'b1;
          end else begin
            ram_re     = 1'b1;
            cur_re_nxt = (pos17 == (w4 - 17'd1));
            cur_ie_nxt = (pos17 == (w4 - 17'd1)) &&
                         (({1'b0, row_r} + 17'd1) >= {1'b0, height_r});
            state_nxt  = S_CONV;
          end
        end
      end

      S_CONV: begin
        if (pend_cnt_r != 2'd2) begin
          if (pend_cnt_r == 2'd0) begin
            px0_nxt = cv_px;
          end else begin
            px1_nxt = cv_px;
          end
          pend_cnt_nxt = pend_cnt_r + 2'd1;
          pend_re_nxt  = cur_re_r;
          pend_ie_nxt  = cur_ie_r;
          state_nxt    = S_RUN;
        end else if (out_free) begin
          // another pixel follows: release the held pair
          out_valid_nxt             = 1'b1;
          out_data_nxt              = '0;
          out_data_nxt.pixel_count  = 2'd2;
          out_data_nxt.red_first    = px0_r.red;
          out_data_nxt.green_first  = px0_r.green;
          out_data_nxt.blue_first   = px0_r.blue;
          out_data_nxt.red_second   = px1_r.red;
          out_data_nxt.green_second = px1_r.green;
          out_data_nxt.blue_second  = px1_r.blue;
          out_data_nxt.row_end      = pend_re_r;
          out_data_nxt.image_end    = pend_ie_r;
          px0_nxt                   = cv_px;
          pend_cnt_nxt              = 2'd1;
          pend_re_nxt               = cur_re_r;
          pend_ie_nxt               = cur_ie_r;
          state_nxt                 = S_RUN;
        end
      end

      S_FIN: begin
        if (pend_cnt_r == '0 && err_r == ERR_NONE) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt             = '0;
          out_data_nxt.pixel_count = pend_cnt_r;
          if (pend_cnt_r != '0) begin
            out_data_nxt.red_first   = px0_r.red;
            out_data_nxt.green_first = px0_r.green;
            out_data_nxt.blue_first  = px0_r.blue;
          end
          if (pend_cnt_r == 2'd2) begin
            out_data_nxt.red_second   = px1_r.red;
            out_data_nxt.green_second = px1_r.green;
            out_data_nxt.blue_second  = px1_r.blue;
          end
          out_data_nxt.row_end     = pend_re_r;
          out_data_nxt.image_end   = pend_ie_r;
          out_data_nxt.last_of_run = 1'b1;
          out_data_nxt.error_code  = err_r;
          pend_cnt_nxt             = '0;
          state_nxt                = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= FLAT_MIN_W;
      height_r    <= 16'd1;
      w3_r        <= 17'd24;
      pos_r       <= '0;
      phase_r     <= PH_HEADER;
      hidx_r      <= '0;
      lit_r       <= '0;
      row_r       <= '0;
      fpb_r       <= '0;
      sticky_r    <= ERR_NONE;
      rem_r       <= '0;
      err_r       <= ERR_NONE;
      pend_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      hidx_r      <= hidx_nxt;
      lit_r       <= lit_nxt;
      row_r       <= row_nxt;
      fpb_r       <= fpb_nxt;
      sticky_r    <= sticky_nxt;
      rem_r       <= rem_nxt;
      err_r       <= err_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_WIDTH: begin
            width_r <= cfg_wdata[14:0];
            w3_r    <= {2'b00, cfg_wdata[14:0]} + {1'b0, cfg_wdata[14:0], 1'b0};
          end
          CFG_HEIGHT: begin
            height_r <= cfg_wdata;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    fs_r       <= fs_nxt;
    px0_r      <= px0_nxt;
    px1_r      <= px1_nxt;
    pend_re_r  <= pend_re_nxt;
    pend_ie_r  <= pend_ie_nxt;
    cur_re_r   <= cur_re_nxt;
    cur_ie_r   <= cur_ie_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_cnt_r != 2'd3)
    else $error("pending pixel count out of range");

  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pixel_count == 2'd0 |->
      out_data.last_of_run && out_data.error_code != ERR_NONE)
    else $error("pixel-less word without error");

  a_conv_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CONV |-> $past(state_r) == S_RUN || $past(state_r) == S_CONV)
    else $error("conversion without buffer read");

  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_of_run |-> out_data.pixel_count == 2'd2)
    else $error("non-final word not full");
`endif

endmodule
